### rtl/tsag_pkg.sv
`default_nettype none

package tsag_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int ADDR_W     = 24;
  localparam int RECIP_SHIFT = 24;
  localparam int DIVIDEND_W = RECIP_SHIFT + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);
  localparam int CFG_INDEX_W = 2;
  localparam int STAGES     = 8;

  typedef logic [DIM_W-1:0]      dim_t;
  typedef logic [COORD_W-1:0]    coord_t;
  typedef logic [DIVIDEND_W-1:0] recip_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_TILE_COUNT   = 2'd2
  } cfg_index_t;

  // Per-axis constants derived from the registers by the setup sequencer.
  typedef struct packed {
    dim_t   base;          // len / N
    dim_t   wide_span;     // (len mod N) * (base + 1)
    recip_t recip_wide;    // 2^24 / (base + 1)
    recip_t recip_narrow;  // 2^24 / base
  } axis_param_t;

  typedef struct packed {
    logic l1;
    logic l2;
    logic l3;
    logic l4;
    logic l5;
  } lane_en_t;

  function automatic dim_t clamp_dim(input dim_t v);
    return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
  endfunction

endpackage

`default_nettype wire

### rtl/tsag_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. start restarts it at any time.
module tsag_divider (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [tsag_pkg::DIVIDEND_W-1:0] dividend,
  input  wire tsag_pkg::dim_t                  divisor,
  output logic      [tsag_pkg::DIVIDEND_W-1:0] quotient,
  output tsag_pkg::dim_t                       remainder,
  output logic                                 done
);

  logic                               running;
  logic [tsag_pkg::DIV_CNT_W-1:0]     cnt;
  logic [tsag_pkg::DIVIDEND_W-1:0]    quo;
  tsag_pkg::dim_t                     rem;
  tsag_pkg::dim_t                     dsr;
  logic [tsag_pkg::DIM_W:0]           trial;
  logic                               fits;
  tsag_pkg::dim_t                     rem_next;

  always_comb begin
    trial    = {rem, quo[tsag_pkg::DIVIDEND_W-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? tsag_pkg::DIM_W'(trial - {1'b0, dsr}) : trial[tsag_pkg::DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= tsag_pkg::DIV_CNT_W'(tsag_pkg::DIVIDEND_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == tsag_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      quo <= {quo[tsag_pkg::DIVIDEND_W-2:0], fits};
      rem <= rem_next;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

### rtl/tsag_setup.sv
`default_nettype none

// Config registers plus a sequencer that derives tile widths and reciprocals.
module tsag_setup (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tsag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire tsag_pkg::dim_t                   cfg_data,
  output tsag_pkg::dim_t                        width,
  output tsag_pkg::dim_t                        height,
  output tsag_pkg::dim_t                        tiles,
  output tsag_pkg::axis_param_t                 param_x,
  output tsag_pkg::axis_param_t                 param_y,
  output logic                                  busy
);

  typedef enum logic [6:0] {
    ST_READY  = 7'b0000001,
    ST_DIV_W  = 7'b0000010,
    ST_DIV_H  = 7'b0000100,
    ST_REC_WP = 7'b0001000,
    ST_REC_W  = 7'b0010000,
    ST_REC_HP = 7'b0100000,
    ST_REC_H  = 7'b1000000
  } state_t;

  localparam logic [tsag_pkg::DIVIDEND_W-1:0] RECIP_ONE =
    tsag_pkg::DIVIDEND_W'(1) << tsag_pkg::RECIP_SHIFT;

  state_t state;
  logic   launched;

  tsag_pkg::dim_t width_raw, height_raw, tiles_raw;
  tsag_pkg::dim_t base_x, base_y, extra_x, extra_y, span_x, span_y;
  tsag_pkg::dim_t base_x_inc, base_y_inc;
  tsag_pkg::recip_t rwide_x, rnarrow_x, rwide_y, rnarrow_y;

  logic                              div_start;
  logic [tsag_pkg::DIVIDEND_W-1:0]   div_dividend;
  tsag_pkg::dim_t                    div_divisor;
  logic [tsag_pkg::DIVIDEND_W-1:0]   div_quotient;
  tsag_pkg::dim_t                    div_remainder;
  logic                              div_done;
  logic [2*tsag_pkg::DIM_W-1:0]      span_x_prod, span_y_prod;
  logic                              step_done;

  assign width  = tsag_pkg::clamp_dim(width_raw);
  assign height = tsag_pkg::clamp_dim(height_raw);
  assign tiles  = tsag_pkg::clamp_dim(tiles_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_raw  <= tsag_pkg::DIM_W'(1);
      height_raw <= tsag_pkg::DIM_W'(1);
      tiles_raw  <= tsag_pkg::DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        tsag_pkg::CFG_IMAGE_WIDTH:  width_raw  <= cfg_data;
        tsag_pkg::CFG_IMAGE_HEIGHT: height_raw <= cfg_data;
        tsag_pkg::CFG_TILE_COUNT:   tiles_raw  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign base_x_inc = base_x + tsag_pkg::DIM_W'(1);
  assign base_y_inc = base_y + tsag_pkg::DIM_W'(1);

  always_comb begin
    case (state)
      ST_DIV_W: begin
        div_dividend = tsag_pkg::DIVIDEND_W'(width);
        div_divisor  = tiles;
      end
      ST_DIV_H: begin
        div_dividend = tsag_pkg::DIVIDEND_W'(height);
        div_divisor  = tiles;
      end
      ST_REC_WP: begin
        div_dividend = RECIP_ONE;
        div_divisor  = base_x_inc;
      end
      ST_REC_W: begin
        div_dividend = RECIP_ONE;
        div_divisor  = base_x;
      end
      ST_REC_HP: begin
        div_dividend = RECIP_ONE;
        div_divisor  = base_y_inc;
      end
      ST_REC_H: begin
        div_dividend = RECIP_ONE;
        div_divisor  = base_y;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  assign busy      = (state != ST_READY);
  assign div_start = busy && !launched;
  assign step_done = launched && div_done && !cfg_we;

  tsag_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quotient),
    .remainder (div_remainder),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_DIV_W;
      launched <= 1'b0;
    end else if (cfg_we) begin
      state    <= ST_DIV_W;
      launched <= 1'b0;
    end else if (busy) begin
      if (!launched) begin
        launched <= 1'b1;
      end else if (div_done) begin
        launched <= 1'b0;
        case (state)
          ST_DIV_W:  state <= ST_DIV_H;
          ST_DIV_H:  state <= ST_REC_WP;
          ST_REC_WP: state <= ST_REC_W;
          ST_REC_W:  state <= ST_REC_HP;
          ST_REC_HP: state <= ST_REC_H;
          default:   state <= ST_READY;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_done) begin
      case (state)
        ST_DIV_W: begin
          base_x  <= div_quotient[tsag_pkg::DIM_W-1:0];
          extra_x <= div_remainder;
        end
        ST_DIV_H: begin
          base_y  <= div_quotient[tsag_pkg::DIM_W-1:0];
          extra_y <= div_remainder;
        end
        ST_REC_WP: rwide_x   <= div_quotient;
        ST_REC_W:  rnarrow_x <= div_quotient;
        ST_REC_HP: rwide_y   <= div_quotient;
        ST_REC_H:  rnarrow_y <= div_quotient;
        default: ;
      endcase
    end
  end

  // Span of the wider tiles never exceeds the axis length.
  assign span_x_prod = extra_x * base_x_inc;
  assign span_y_prod = extra_y * base_y_inc;

  always_ff @(posedge clk) begin
    span_x <= span_x_prod[tsag_pkg::DIM_W-1:0];
    span_y <= span_y_prod[tsag_pkg::DIM_W-1:0];
  end

  assign param_x = '{base: base_x, wide_span: span_x,
                     recip_wide: rwide_x, recip_narrow: rnarrow_x};
  assign param_y = '{base: base_y, wide_span: span_y,
                     recip_wide: rwide_y, recip_narrow: rnarrow_y};

endmodule

`default_nettype wire

### rtl/tsag_axis_lane.sv
`default_nettype none

// One axis: tile offset by reciprocal multiply plus one correction, times N.
module tsag_axis_lane (
  input  wire logic                  clk,
  input  wire tsag_pkg::lane_en_t    en,
  input  wire tsag_pkg::coord_t      coord,
  input  wire tsag_pkg::axis_param_t param,
  input  wire tsag_pkg::dim_t        tiles,
  output tsag_pkg::dim_t             src
);

  localparam int PROD_W = tsag_pkg::COORD_W + tsag_pkg::DIVIDEND_W;

  logic                  wide;
  tsag_pkg::coord_t      c1, c2, c3;
  tsag_pkg::dim_t        d1, d2, d3;
  tsag_pkg::recip_t      r1;
  logic                  zero1, zero2, zero3;
  logic [PROD_W-1:0]     qprod;
  tsag_pkg::coord_t      q2;
  logic [tsag_pkg::COORD_W+tsag_pkg::DIM_W-1:0] qd_prod, s_prod;
  tsag_pkg::coord_t      qd3;
  tsag_pkg::coord_t      rem_raw;
  logic [tsag_pkg::DIM_W-1:0] rem_fix;
  tsag_pkg::coord_t      off4;

  assign wide = {1'b0, coord} < param.wide_span;

  // L1: pick the tile class and its divisor
  always_ff @(posedge clk) begin
    if (en.l1) begin
      c1    <= wide ? coord : coord - param.wide_span[tsag_pkg::COORD_W-1:0];
      d1    <= wide ? param.base + tsag_pkg::DIM_W'(1) : param.base;
      r1    <= wide ? param.recip_wide : param.recip_narrow;
      zero1 <= !wide && (param.base == '0);
    end
  end

  // L2: quotient estimate, low by at most one
  assign qprod = c1 * r1;

  always_ff @(posedge clk) begin
    if (en.l2) begin
      q2    <= qprod[tsag_pkg::RECIP_SHIFT +: tsag_pkg::COORD_W];
      c2    <= c1;
      d2    <= d1;
      zero2 <= zero1;
    end
  end

  // L3: back-multiply
  assign qd_prod = q2 * d2;

  always_ff @(posedge clk) begin
    if (en.l3) begin
      qd3   <= qd_prod[tsag_pkg::COORD_W-1:0];
      c3    <= c2;
      d3    <= d2;
      zero3 <= zero2;
    end
  end

  // L4: remainder with one correction step
  assign rem_raw = c3 - qd3;
  assign rem_fix = ({1'b0, rem_raw} >= d3) ? {1'b0, rem_raw} - d3 : {1'b0, rem_raw};

  always_ff @(posedge clk) begin
    if (en.l4) begin
      off4 <= zero3 ? '0 : rem_fix[tsag_pkg::COORD_W-1:0];
    end
  end

  // L5: scale by N; result is below the axis length
  assign s_prod = off4 * tiles;

  always_ff @(posedge clk) begin
    if (en.l5) begin
      src <= s_prod[tsag_pkg::DIM_W-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/tile_source_address_gen_core.sv
`default_nettype none

// Channel  | handshake                 | payload
// ---------+---------------------------+---------------------------------------
// in       | in_valid / in_ready       | out_x, out_y
// out      | out_valid / out_ready     | src_x, src_y, src_address, out_of_range
// cfg      | cfg_we (no wait)          | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready is high and no setup pass runs.
// Stage 0 registers the coordinate and range check, stages 1-5 run the two axis
// lanes (select, reciprocal multiply, back-multiply, correct, scale by N),
// stage 6 multiplies src_y by the width, stage 7 adds src_x into the output register.
// After reset and after every config write, a setup pass
// (six 25-step divisions on one shared divider) holds in_ready low.
// Stalls: each stage advances when it is empty or the next one moves, so
// bubbles close up behind a stalled output and nothing is dropped or repeated.
module tile_source_address_gen_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire tsag_pkg::coord_t                 out_x,
  input  wire tsag_pkg::coord_t                 out_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output tsag_pkg::coord_t                      src_x,
  output tsag_pkg::coord_t                      src_y,
  output logic [tsag_pkg::ADDR_W-1:0]           src_address,
  output logic                                  out_of_range,
  input  wire logic                             cfg_we,
  input  wire logic [tsag_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire tsag_pkg::dim_t                   cfg_data
);

  localparam int LAST = tsag_pkg::STAGES - 1;

  tsag_pkg::dim_t        width, height, tiles;
  tsag_pkg::axis_param_t param_x, param_y;
  logic                  busy;
  logic                  bad_cfg;

  logic [LAST:0]         v;      // stage valid bits
  logic [LAST:0]         en;     // stage load enables
  logic [LAST-1:0]       oor;    // out-of-range flag riding along
  tsag_pkg::coord_t      x0, y0;
  tsag_pkg::dim_t        sx5, sy5, sx6;
  tsag_pkg::coord_t      src_y_hold;
  logic [tsag_pkg::ADDR_W-1:0] row6;
  logic [2*tsag_pkg::DIM_W-1:0] row_prod;
  tsag_pkg::lane_en_t    lane_en;
  logic                  in_oor;

  tsag_setup u_setup (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .width     (width),
    .height    (height),
    .tiles     (tiles),
    .param_x   (param_x),
    .param_y   (param_y),
    .busy      (busy)
  );

  // Backward enable chain: a stage loads if empty or if its item moves on.
  always_comb begin
    en[LAST] = !v[LAST] || out_ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0] && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid && in_ready;
      end
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 0: capture and range check. A zero register covers no pixel.
  assign bad_cfg = (width == '0) || (height == '0) || (tiles == '0);
  assign in_oor  = bad_cfg || ({1'b0, out_x} >= width) || ({1'b0, out_y} >= height);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0     <= out_x;
      y0     <= out_y;
      oor[0] <= in_oor;
    end
    for (int i = 1; i < LAST; i++) begin
      if (en[i]) begin
        oor[i] <= oor[i-1];
      end
    end
  end

  // Stages 1-5
  assign lane_en = '{l1: en[1], l2: en[2], l3: en[3], l4: en[4], l5: en[5]};

  tsag_axis_lane u_lane_x (
    .clk   (clk),
    .en    (lane_en),
    .coord (x0),
    .param (param_x),
    .tiles (tiles),
    .src   (sx5)
  );

  tsag_axis_lane u_lane_y (
    .clk   (clk),
    .en    (lane_en),
    .coord (y0),
    .param (param_y),
    .tiles (tiles),
    .src   (sy5)
  );

  // Stage 6: row offset
  assign row_prod = sy5 * width;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      row6 <= row_prod[tsag_pkg::ADDR_W-1:0];
      sx6  <= sx5;
      src_y_hold <= sy5[tsag_pkg::COORD_W-1:0];
    end
  end

  // Stage 7: output register; flagged items read as zero
  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_of_range <= oor[6];
      src_x        <= oor[6] ? '0 : sx6[tsag_pkg::COORD_W-1:0];
      src_y        <= oor[6] ? '0 : src_y_hold;
      src_address  <= oor[6] ? '0 : row6 + tsag_pkg::ADDR_W'(sx6);
    end
  end

  assign out_valid = v[LAST];

`ifndef SYNTHESIS
  // flagged items carry no coordinate
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> (src_x == '0) && (src_y == '0) && (src_address == '0))
    else $error("out-of-range item with nonzero fields");

  // a source pixel always lies inside the image
  a_src_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_of_range |-> ({1'b0, src_x} < width) && ({1'b0, src_y} < height))
    else $error("source coordinate outside image");

  // a config write always triggers the setup pass
  a_cfg_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input accepted during setup pass");
`endif

endmodule

`default_nettype wire
